// ----- src/alu_add_sub_with_flags_macros.svh -----
// assertion macros for the add/subtract alu with flags
`ifndef ALU_ADD_SUB_WITH_FLAGS_MACROS_SVH
`define ALU_ADD_SUB_WITH_FLAGS_MACROS_SVH

// same-cycle implication, checked out of reset
`define ALU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ALU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/aluas_pkg.sv -----
// package with request codes and width constants for the add/subtract alu
`timescale 1ns / 1ps

package aluas_pkg;

    // request codes
    typedef enum logic [2:0] {
        REQ_ADD   = 3'd0,
        REQ_SUB   = 3'd1,
        REQ_ADDC  = 3'd2,
        REQ_SUBB  = 3'd3,
        REQ_SETZN = 3'd4,
        REQ_LOAD  = 3'd5
    } req_type_t;

    localparam int unsigned DATA_W = 16;

    localparam logic [DATA_W-1:0] BYTE_MASK = 16'h00ff;
    localparam logic [DATA_W-1:0] WORD_MASK = 16'hffff;
    localparam logic [DATA_W-1:0] BYTE_TOP  = 16'h0080;
    localparam logic [DATA_W-1:0] WORD_TOP  = 16'h8000;

    // flag set kept by the block
    typedef struct packed {
        logic z;
        logic n;
        logic v;
        logic vt;
        logic c;
    } flags_t;

endpackage

// ----- src/alu_add_sub_with_flags.sv -----
// top level of the add/subtract alu with zero, negative, overflow, sticky and carry flags
`timescale 1ns / 1ps
`include "alu_add_sub_with_flags_macros.svh"

// Usage:
//   Input channel: in_valid / in_stall with req_type, word_mode, operand_a and
//   operand_b. A request is taken at a rising edge with in_valid high and
//   in_stall low.
//   Output channel: out_valid / out_stall with alu_result and the five flags as
//   they stand after the request. Exactly one result per request, in order.
//   A request is captured in the input register, worked through one adder
//   and lands in the result register, from which its result is shown.
//   Throughput: one request per cycle while the receiver does not stall. The
//   flag register feeds the next request's carry-in directly, so back-to-back
//   dependent requests run at full rate.
//   Reset (rst_n low, asynchronous) clears both stage valids and flags_reg.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more request, then in_stall rises until the result is
//   taken. Flags change only when a request moves into the result register.
module alu_add_sub_with_flags (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  req_type,
    input  logic        word_mode,
    input  logic [15:0] operand_a,
    input  logic [15:0] operand_b,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] alu_result,
    output logic        zero_flag,
    output logic        negative_flag,
    output logic        overflow_flag,
    output logic        sticky_overflow_flag,
    output logic        carry_flag
);

    localparam int unsigned W = aluas_pkg::DATA_W;

    // input stage
    logic                   s1_valid_reg;
    logic [2:0]             s1_type_reg;
    logic                   s1_word_reg;
    logic [W-1:0]           s1_a_reg;
    logic [W-1:0]           s1_b_reg;

    // result stage and flag state
    logic                   out_valid_reg;
    logic [W-1:0]           result_reg;
    aluas_pkg::flags_t      out_flags_reg;
    aluas_pkg::flags_t      flags_reg;

    logic                   s1_adv;
    logic                   in_take;

    // datapath signals
    logic [W-1:0]           mask;
    logic [W-1:0]           top;
    logic [W-1:0]           a_m;
    logic [W-1:0]           b_m;
    logic [W-1:0]           bx;
    logic                   is_sub;
    logic                   cin;
    logic [W:0]             sum;
    logic [W-1:0]           arith_res;
    logic                   cout;
    logic                   ovf;
    logic                   res_zero;
    logic                   res_neg;
    logic                   a_zero;
    logic                   a_neg;
    logic [W-1:0]           result_next;
    aluas_pkg::flags_t      flags_next;

    // handshake
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;

    // width selection and operand masking
    assign mask = s1_word_reg ? aluas_pkg::WORD_MASK : aluas_pkg::BYTE_MASK;
    assign top  = s1_word_reg ? aluas_pkg::WORD_TOP  : aluas_pkg::BYTE_TOP;
    assign a_m  = s1_a_reg & mask;
    assign b_m  = s1_b_reg & mask;

    // subtract as a plus inverted b plus not-borrow
    always_comb
    begin
        is_sub = 1'b0;
        cin    = 1'b0;
        case (s1_type_reg)
            aluas_pkg::REQ_ADD:
            begin
                is_sub = 1'b0;
                cin    = 1'b0;
            end
            aluas_pkg::REQ_ADDC:
            begin
                is_sub = 1'b0;
                cin    = flags_reg.c;
            end
            aluas_pkg::REQ_SUB:
            begin
                is_sub = 1'b1;
                cin    = 1'b1;
            end
            aluas_pkg::REQ_SUBB:
            begin
                is_sub = 1'b1;
                cin    = flags_reg.c;
            end
            default:
            begin
                is_sub = 1'b0;
                cin    = 1'b0;
            end
        endcase
    end

    // single adder with carry out at the selected width
    assign bx        = is_sub ? (~b_m & mask) : b_m;
    assign sum       = {1'b0, a_m} + {1'b0, bx} + {{W{1'b0}}, cin};
    assign arith_res = sum[W-1:0] & mask;
    assign cout      = s1_word_reg ? sum[W] : sum[W/2];
    assign ovf       = |(~(a_m ^ bx) & (a_m ^ arith_res) & top);
    assign res_zero  = (arith_res == '0);
    assign res_neg   = !res_zero && (|(arith_res & top));
    assign a_zero    = (a_m == '0);
    assign a_neg     = !a_zero && (|(a_m & top));

    // next result and flags per request
    always_comb
    begin
        result_next = '0;
        flags_next  = flags_reg;
        case (s1_type_reg)
            aluas_pkg::REQ_ADD, aluas_pkg::REQ_ADDC:
            begin
                result_next   = arith_res;
                flags_next.z  = res_zero;
                flags_next.n  = res_neg;
                flags_next.c  = cout;
                flags_next.v  = ovf;
                flags_next.vt = flags_reg.vt | ovf;
            end
            aluas_pkg::REQ_SUB, aluas_pkg::REQ_SUBB:
            begin
                result_next  = arith_res;
                flags_next.z = res_zero;
                flags_next.n = res_neg;
                flags_next.c = cout;
                flags_next.v = ovf;
            end
            aluas_pkg::REQ_SETZN:
            begin
                result_next  = a_m;
                flags_next.z = a_zero;
                flags_next.n = a_neg;
                flags_next.c = 1'b0;
                flags_next.v = 1'b0;
            end
            aluas_pkg::REQ_LOAD:
            begin
                result_next   = a_m;
                flags_next.z  = a_m[4];
                flags_next.n  = a_m[3];
                flags_next.v  = a_m[2];
                flags_next.vt = a_m[1];
                flags_next.c  = a_m[0];
            end
            default:
            begin
                result_next = '0;
                flags_next  = flags_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_type_reg <= req_type;
            s1_word_reg <= word_mode;
            s1_a_reg    <= operand_a;
            s1_b_reg    <= operand_b;
        end
        if (s1_adv)
        begin
            result_reg    <= result_next;
            out_flags_reg <= flags_next;
        end
    end

    // outputs
    assign out_valid            = out_valid_reg;
    assign alu_result           = result_reg;
    assign zero_flag            = out_flags_reg.z;
    assign negative_flag        = out_flags_reg.n;
    assign overflow_flag        = out_flags_reg.v;
    assign sticky_overflow_flag = out_flags_reg.vt;
    assign carry_flag           = out_flags_reg.c;

    // checks
    `ALU_ASSERT_NOW(a_stall_needs_item, !s1_valid_reg, !in_stall, "stall with empty input stage")
    `ALU_ASSERT_NOW(a_out_flags_match, out_valid_reg, out_flags_reg == flags_reg, "shown flags differ from state")
    `ALU_ASSERT_NEXT(a_flags_hold, !s1_adv, $stable(flags_reg), "flags changed without a request")
    `ALU_ASSERT_NEXT(a_sticky_clear_by_load, s1_adv && flags_reg.vt && (s1_type_reg != aluas_pkg::REQ_LOAD), flags_reg.vt, "sticky overflow cleared without flag load")

endmodule

// ----- tb/tb_alu_add_sub_with_flags.sv -----
// self-checking testbench for the add/subtract alu with flags
`timescale 1ns / 1ps
module tb_alu_add_sub_with_flags;

    // request codes the block does not define; they must leave the flags alone
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    localparam logic [15:0] WORD_CORNERS [4] = '{16'h0000, 16'hffff, 16'h7fff, 16'h8000};

    typedef struct packed {
        logic [15:0]       value;
        aluas_pkg::flags_t flags;
    } alu_response_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  req_type;
    logic        word_mode;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] alu_result;
    logic        zero_flag;
    logic        negative_flag;
    logic        overflow_flag;
    logic        sticky_overflow_flag;
    logic        carry_flag;

    // predicted flag register and the responses still owed by the block
    aluas_pkg::flags_t model_flags;
    alu_response_t     pending_responses[$];
    alu_response_t     oldest_response;

    int send_idle_pct;
    int recv_stall_pct;
    int mismatches;
    int responses_checked;
    int requests_sent;
    int cycle_count;
    int kind_count[8];

    alu_add_sub_with_flags DUT (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .req_type             (req_type),
        .word_mode            (word_mode),
        .operand_a            (operand_a),
        .operand_b            (operand_b),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .alu_result           (alu_result),
        .zero_flag            (zero_flag),
        .negative_flag        (negative_flag),
        .overflow_flag        (overflow_flag),
        .sticky_overflow_flag (sticky_overflow_flag),
        .carry_flag           (carry_flag)
    );

    // clock
    always #1 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, pending_responses.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // random receiver back-pressure
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // zero and negative from a result at the selected width
    function automatic void update_zero_negative(input logic [15:0] res, input logic [15:0] top);
        model_flags.z = (res == 16'h0000);
        model_flags.n = !model_flags.z && ((res & top) != 16'h0000);
    endfunction

    // advance the flag register by one request and return the response it yields
    function automatic alu_response_t compute_alu_response(input logic [2:0] kind,
            input logic wide, input logic [15:0] op_a, input logic [15:0] op_b);
        logic [15:0]   mask;
        logic [15:0]   top;
        logic [15:0]   a;
        logic [15:0]   b;
        logic [15:0]   res;
        logic [16:0]   total;
        logic          extra;
        alu_response_t resp;
        mask = wide ? aluas_pkg::WORD_MASK : aluas_pkg::BYTE_MASK;
        top  = wide ? aluas_pkg::WORD_TOP : aluas_pkg::BYTE_TOP;
        a    = op_a & mask;
        b    = op_b & mask;
        res  = 16'h0000;
        case (kind)
            aluas_pkg::REQ_ADD, aluas_pkg::REQ_ADDC:
            begin
                // carry-in only for add with carry
                extra = (kind == aluas_pkg::REQ_ADDC) && model_flags.c;
                total = {1'b0, a} + {1'b0, b} + 17'(extra);
                res   = total[15:0] & mask;
                update_zero_negative(res, top);
                model_flags.c = (total > {1'b0, mask});
                model_flags.v = ((~(a ^ b) & (a ^ res) & top) != 16'h0000);
                if (model_flags.v)
                    model_flags.vt = 1'b1;
            end
            aluas_pkg::REQ_SUB, aluas_pkg::REQ_SUBB:
            begin
                // borrow-in is the inverse of carry for subtract with borrow
                extra = (kind == aluas_pkg::REQ_SUBB) && !model_flags.c;
                total = {1'b0, b} + 17'(extra);
                res   = (a - b - 16'(extra)) & mask;
                update_zero_negative(res, top);
                model_flags.c = ({1'b0, a} >= total);
                model_flags.v = (((a ^ b) & (a ^ res) & top) != 16'h0000);
            end
            aluas_pkg::REQ_SETZN:
            begin
                res = a;
                update_zero_negative(res, top);
                model_flags.c = 1'b0;
                model_flags.v = 1'b0;
            end
            aluas_pkg::REQ_LOAD:
            begin
                // bits 4..0 map straight onto z, n, v, vt, c
                res         = a;
                model_flags = aluas_pkg::flags_t'(a[4:0]);
            end
            default: ;
        endcase
        resp.value = res;
        resp.flags = model_flags;
        return resp;
    endfunction

    // present one request, hold it until taken, then record its response
    task automatic send_request(input logic [2:0] kind, input logic wide,
            input logic [15:0] op_a, input logic [15:0] op_b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= kind;
        word_mode <= wide;
        operand_a <= op_a;
        operand_b <= op_b;
        do
            @(posedge clk);
        while (in_stall);
        pending_responses.push_back(compute_alu_response(kind, wide, op_a, op_b));
        requests_sent++;
        kind_count[kind]++;
    endtask

    // stop sending until every owed response has come back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void check_field(input string field, input logic [15:0] want,
            input logic [15:0] got);
        if (got !== want)
        begin
            if (mismatches < MAX_REPORTS)
                $display("mismatch in %s of response %0d: expected %h, got %h",
                         field, responses_checked, want, got);
            mismatches++;
        end
    endfunction

    // compare each accepted response with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_responses.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("response with no request outstanding: alu_result %h", alu_result);
                mismatches++;
            end
            else
            begin
                oldest_response = pending_responses.pop_front();
                check_field("alu_result", oldest_response.value, alu_result);
                check_field("zero_flag", 16'(oldest_response.flags.z), 16'(zero_flag));
                check_field("negative_flag", 16'(oldest_response.flags.n), 16'(negative_flag));
                check_field("overflow_flag", 16'(oldest_response.flags.v), 16'(overflow_flag));
                check_field("sticky_overflow_flag", 16'(oldest_response.flags.vt),
                            16'(sticky_overflow_flag));
                check_field("carry_flag", 16'(oldest_response.flags.c), 16'(carry_flag));
                responses_checked++;
            end
        end
    end

    // operands biased toward the sign and carry boundaries at both widths
    function automatic logic [15:0] pick_operand();
        case ($urandom_range(6))
            0: return {8'($urandom), 8'h00};
            1: return {8'($urandom), 8'hff};
            2: return {8'($urandom), 8'h7f};
            3: return {8'($urandom), 8'h80};
            4: return WORD_CORNERS[$urandom_range(3)];
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly arithmetic, some flag loads, a few undefined codes
    function automatic logic [2:0] pick_kind();
        int roll;
        roll = $urandom_range(99);
        if (roll < 4)
            return $urandom_range(1) ? REQ_SPARE_6 : REQ_SPARE_7;
        else if (roll < 12)
            return aluas_pkg::REQ_LOAD;
        else
            return 3'($urandom_range(aluas_pkg::REQ_ADD, aluas_pkg::REQ_SETZN));
    endfunction

    // carry out, zero and signed overflow at both widths
    task automatic test_add_sub_extremes();
        send_request(aluas_pkg::REQ_ADD, 1'b0, 16'h12ff, 16'hab01);
        send_request(aluas_pkg::REQ_ADD, 1'b0, 16'h007f, 16'h0001);
        send_request(aluas_pkg::REQ_ADD, 1'b1, 16'hffff, 16'hffff);
        send_request(aluas_pkg::REQ_ADD, 1'b1, 16'h7fff, 16'h0001);
        send_request(aluas_pkg::REQ_SUB, 1'b0, 16'h0000, 16'h0001);
        send_request(aluas_pkg::REQ_SUB, 1'b1, 16'h8000, 16'h0001);
        send_request(aluas_pkg::REQ_SUB, 1'b1, 16'h1234, 16'h1234);
        send_request(aluas_pkg::REQ_SUB, 1'b0, 16'hff80, 16'h5501);
    endtask

    // carry and borrow fed forward between consecutive requests
    task automatic test_carry_chains();
        send_request(aluas_pkg::REQ_ADD, 1'b1, 16'hffff, 16'h0001);
        send_request(aluas_pkg::REQ_ADDC, 1'b1, 16'h7fff, 16'h0000);
        send_request(aluas_pkg::REQ_SUB, 1'b0, 16'h0000, 16'h0001);
        send_request(aluas_pkg::REQ_SUBB, 1'b0, 16'h0080, 16'h0000);
        send_request(aluas_pkg::REQ_SUBB, 1'b1, 16'h0000, 16'hffff);
        send_request(aluas_pkg::REQ_SUBB, 1'b1, 16'hffff, 16'hffff);
    endtask

    // set zn from a value, and direct flag loads including zero with negative
    task automatic test_flag_set_and_load();
        send_request(aluas_pkg::REQ_SETZN, 1'b0, 16'hff80, 16'hffff);
        send_request(aluas_pkg::REQ_SETZN, 1'b1, 16'h0000, 16'hffff);
        send_request(aluas_pkg::REQ_SETZN, 1'b1, 16'h8000, 16'h0000);
        send_request(aluas_pkg::REQ_LOAD, 1'b1, 16'h001f, 16'h0000);
        send_request(aluas_pkg::REQ_LOAD, 1'b1, 16'hffe0, 16'hffff);
        send_request(aluas_pkg::REQ_LOAD, 1'b0, 16'hff0a, 16'h1234);
    endtask

    // undefined request codes report zero and keep the flags
    task automatic test_spare_codes();
        send_request(REQ_SPARE_6, 1'b1, 16'hffff, 16'hffff);
        send_request(REQ_SPARE_7, 1'b0, 16'h0080, 16'h0001);
    endtask

    // sticky overflow survives subtraction across an idle pipeline, load clears it
    task automatic test_sticky_clear();
        send_request(aluas_pkg::REQ_ADD, 1'b0, 16'h007f, 16'h0001);
        wait_for_drain();
        send_request(aluas_pkg::REQ_SUB, 1'b1, 16'h8000, 16'h0001);
        send_request(aluas_pkg::REQ_LOAD, 1'b0, 16'h0000, 16'h0000);
        wait_for_drain();
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
            input int count);
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
        repeat (count)
            send_request(pick_kind(), 1'($urandom), pick_operand(), pick_operand());
    endtask

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        req_type          = aluas_pkg::REQ_ADD;
        word_mode         = 1'b0;
        operand_a         = 16'h0000;
        operand_b         = 16'h0000;
        out_stall         = 1'b0;
        model_flags       = '0;
        send_idle_pct     = 30;
        recv_stall_pct    = 30;
        mismatches        = 0;
        responses_checked = 0;
        requests_sent     = 0;
        cycle_count       = 0;
        foreach (kind_count[i])
            kind_count[i] = 0;

        // reset
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_add_sub_extremes();
        test_carry_chains();
        test_flag_set_and_load();
        test_spare_codes();
        test_sticky_clear();
        test_random_traffic(29, 84, 480);
        test_random_traffic(84, 29, 480);
        test_random_traffic(0, 0, 470);
        wait_for_drain();

        $display("covered %0d requests: add %0d, sub %0d, add-carry %0d, sub-borrow %0d,",
                 requests_sent, kind_count[aluas_pkg::REQ_ADD], kind_count[aluas_pkg::REQ_SUB],
                 kind_count[aluas_pkg::REQ_ADDC], kind_count[aluas_pkg::REQ_SUBB]);
        $display("set-zn %0d, load %0d, undefined %0d; %0d responses checked, %0d mismatches",
                 kind_count[aluas_pkg::REQ_SETZN], kind_count[aluas_pkg::REQ_LOAD],
                 kind_count[REQ_SPARE_6] + kind_count[REQ_SPARE_7],
                 responses_checked, mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
